FILE: hdl/mhlmd_pkg.sv
// ----------------------------------------------------------------------------
// mhlmd_pkg: shared types and constants for the hi/lo multiply-divide unit
// command codes, transaction payloads and sequencer states
// ----------------------------------------------------------------------------
package mhlmd_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 4;
    localparam int WORD_LANES = 4;
    localparam int IDX_W      = 2;
    localparam int CNT_W      = 5;

    typedef enum logic [2:0] {
        CMD_DIV    = 3'd0,
        CMD_DIVU   = 3'd1,
        CMD_MULT   = 3'd2,
        CMD_MULTU  = 3'd3,
        CMD_PDIVBW = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [WORD_W-1:0] rs_w0;
        logic [WORD_W-1:0] rs_w1;
        logic [WORD_W-1:0] rs_w2;
        logic [WORD_W-1:0] rs_w3;
        logic [WORD_W-1:0] rt_w0;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] lo_w0;
        logic [WORD_W-1:0] lo_w1;
        logic [WORD_W-1:0] lo_w2;
        logic [WORD_W-1:0] lo_w3;
        logic [WORD_W-1:0] hi_w0;
        logic [WORD_W-1:0] hi_w1;
        logic [WORD_W-1:0] hi_w2;
        logic [WORD_W-1:0] hi_w3;
    } t_out;

endpackage

FILE: hdl/mips_hi_lo_mult_div_unit.sv
// ----------------------------------------------------------------------------
// mips_hi_lo_mult_div_unit: iterative multiply/divide with 128-bit LO and HI
// one 33-bit add/subtract unit runs a one-bit-per-cycle sequence
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_data) takes one command
//   transaction: DIV, DIVU, MULT, MULTU or PDIVBW with its operands
//   output channel (o_out_valid / i_out_stall / o_out_data) returns all eight
//   LO and HI words after that command, one transaction per command
// sequence and throughput
//   scalar commands: a setup state, then shift/add or shift/subtract iteration
//   on the shared adder, then a sign-fix state, then the result is shown
//   PDIVBW repeats setup/iterate/fix once per lane
//   divide by zero and unknown codes skip the iteration and report at once
//   one command at a time: o_in_stall is high from accept until the result
//   transaction has been taken
// reset
//   synchronous active-low i_rst_n clears LO, HI and returns to idle
// receiver stall
//   the result is held in the LO/HI registers and stays put while
//   i_out_stall is high; no new command is taken meanwhile
// ----------------------------------------------------------------------------
module mips_hi_lo_mult_div_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mhlmd_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mhlmd_pkg::t_out  o_out_data
);
    import mhlmd_pkg::*;

    // control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_lane, n_lane;

    // architectural state
    logic [WORD_W-1:0]  r_lo [NUM_WORDS];
    logic [WORD_W-1:0]  n_lo [NUM_WORDS];
    logic [WORD_W-1:0]  r_hi [NUM_WORDS];
    logic [WORD_W-1:0]  n_hi [NUM_WORDS];

    // working registers
    logic [2:0]         r_cmd, n_cmd;
    logic [WORD_W-1:0]  r_rs [NUM_WORDS];
    logic [WORD_W-1:0]  n_rs [NUM_WORDS];
    logic [WORD_W-1:0]  r_rt, n_rt;
    logic [WORD_W-1:0]  r_acc, n_acc;   // remainder or product high
    logic [WORD_W-1:0]  r_q, n_q;       // dividend/quotient or multiplier/product low
    logic [WORD_W-1:0]  r_div, n_div;   // divisor or multiplicand magnitude
    logic               r_negq, n_negq;
    logic               r_negr, n_negr;

    // shared adder
    logic [WORD_W:0]    add_a, add_b;
    logic               add_cin;
    logic [WORD_W:0]    add_sum;
    logic               add_cout;

    logic               is_mul, is_signed;
    logic               na, nb;
    logic [WORD_W-1:0]  qv, rv;
    logic [2*WORD_W-1:0] prod_mag, prod;
    logic [WORD_W-1:0]  rt_half;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);
    localparam logic [IDX_W-1:0] LAST_LANE = IDX_W'(WORD_LANES - 1);

    assign is_mul    = (r_cmd == CMD_MULT) || (r_cmd == CMD_MULTU);
    assign is_signed = (r_cmd == CMD_DIV) || (r_cmd == CMD_MULT) || (r_cmd == CMD_PDIVBW);
    assign na        = is_signed & r_rs[0][WORD_W-1];
    assign nb        = is_signed & r_rt[WORD_W-1];
    assign rt_half   = {{(WORD_W-16){i_in_data.rt_w0[15]}}, i_in_data.rt_w0[15:0]};

    // multiply adds the multiplicand into the high half, divide subtracts
    // the divisor from the shifted partial remainder
    always_comb begin
        if (is_mul) begin
            add_a   = {1'b0, r_acc};
            add_b   = r_q[0] ? {1'b0, r_div} : '0;
            add_cin = 1'b0;
        end else begin
            add_a   = {r_acc, r_q[WORD_W-1]};
            add_b   = ~{1'b0, r_div};
            add_cin = 1'b1;
        end
        {add_cout, add_sum} = {1'b0, add_a} + {1'b0, add_b} + {{(WORD_W+1){1'b0}}, add_cin};
    end

    // sign correction of the finished magnitudes
    assign qv       = r_negq ? (~r_q + WORD_W'(1)) : r_q;
    assign rv       = r_negr ? (~r_acc + WORD_W'(1)) : r_acc;
    assign prod_mag = {r_acc, r_q};
    assign prod     = r_negq ? (~prod_mag + (2*WORD_W)'(1)) : prod_mag;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lane  = r_lane;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_cmd   = r_cmd;
        n_rs    = r_rs;
        n_rt    = r_rt;
        n_acc   = r_acc;
        n_q     = r_q;
        n_div   = r_div;
        n_negq  = r_negq;
        n_negr  = r_negr;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.cmd;
                    n_rs[0] = i_in_data.rs_w0;
                    n_rs[1] = i_in_data.rs_w1;
                    n_rs[2] = i_in_data.rs_w2;
                    n_rs[3] = i_in_data.rs_w3;
                    n_rt    = (i_in_data.cmd == CMD_PDIVBW) ? rt_half : i_in_data.rt_w0;
                    n_lane  = '0;
                    case (i_in_data.cmd)
                        CMD_DIV, CMD_DIVU: begin
                            n_state = (i_in_data.rt_w0 == '0) ? ST_DONE : ST_SETUP;
                        end
                        CMD_MULT, CMD_MULTU: begin
                            n_state = ST_SETUP;
                        end
                        CMD_PDIVBW: begin
                            n_state = (i_in_data.rt_w0[15:0] == 16'd0) ? ST_DONE : ST_SETUP;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                n_q     = na ? (~r_rs[0] + WORD_W'(1)) : r_rs[0];
                n_div   = nb ? (~r_rt + WORD_W'(1)) : r_rt;
                n_acc   = '0;
                n_negq  = na ^ nb;
                n_negr  = na;
                n_cnt   = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (is_mul) begin
                    n_acc = add_sum[WORD_W:1];
                    n_q   = {add_sum[0], r_q[WORD_W-1:1]};
                end else begin
                    n_acc = add_cout ? add_sum[WORD_W-1:0] : {r_acc[WORD_W-2:0], r_q[WORD_W-1]};
                    n_q   = {r_q[WORD_W-2:0], add_cout};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (is_mul) begin
                    n_lo[0] = prod[WORD_W-1:0];
                    n_lo[1] = {WORD_W{is_signed & prod[WORD_W-1]}};
                    n_hi[0] = prod[2*WORD_W-1:WORD_W];
                    n_hi[1] = {WORD_W{is_signed & prod[2*WORD_W-1]}};
                    n_state = ST_DONE;
                end else if (r_cmd == CMD_PDIVBW) begin
                    n_lo[r_lane] = qv;
                    n_hi[r_lane] = rv;
                    // next lane moves into word 0 of the operand line
                    for (int i = 0; i < NUM_WORDS - 1; i++) begin
                        n_rs[i] = r_rs[i+1];
                    end
                    n_rs[NUM_WORDS-1] = r_rs[NUM_WORDS-1];
                    if (r_lane == LAST_LANE) begin
                        n_state = ST_DONE;
                    end else begin
                        n_lane  = r_lane + IDX_W'(1);
                        n_state = ST_SETUP;
                    end
                end else begin
                    n_lo[0] = qv;
                    n_lo[1] = {WORD_W{is_signed & qv[WORD_W-1]}};
                    n_hi[0] = rv;
                    n_hi[1] = {WORD_W{is_signed & rv[WORD_W-1]}};
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lo    <= '{default: '0};
            r_hi    <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_lane <= n_lane;
        r_cmd  <= n_cmd;
        r_rs   <= n_rs;
        r_rt   <= n_rt;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_div  <= n_div;
        r_negq <= n_negq;
        r_negr <= n_negr;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_DONE);
    assign o_out_data  = '{lo_w0: r_lo[0], lo_w1: r_lo[1], lo_w2: r_lo[2], lo_w3: r_lo[3],
                           hi_w0: r_hi[0], hi_w1: r_hi[1], hi_w2: r_hi[2], hi_w3: r_hi[3]};

    // step counter advances by one through the iteration
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt != LAST_STEP) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("iteration counter skipped");

    // restoring divide always leaves a remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX && !is_mul) |-> (r_acc < r_div))
        else $error("partial remainder not below divisor");

    // only the lane command ever walks past lane zero
    a_lane_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX && r_cmd != CMD_PDIVBW) |-> (r_lane == '0))
        else $error("lane index moved on a scalar command");

    // a new command is never taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

endmodule
